/* src/mips_subset_cpu_step_macros.svh */
// assertion macros for the rtl
`ifndef MIPS_SUBSET_CPU_STEP_MACROS_SVH
`define MIPS_SUBSET_CPU_STEP_MACROS_SVH
`ifndef ASSERT_OFF
`define MSS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MSS_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define MSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* src/mss_pkg.sv */
`timescale 1ns / 1ps
package mss_pkg;

   localparam int unsigned DATA_BYTES = 1024;
   localparam int unsigned REG_COUNT  = 32;
   localparam int unsigned MEM_ROWS   = DATA_BYTES / 4;
   localparam int unsigned ROW_W      = $clog2(MEM_ROWS);
   localparam int unsigned REG_W      = $clog2(REG_COUNT);

   typedef enum logic [1:0] {
      CMD_EXEC      = 2'd0,
      CMD_LOAD_WORD = 2'd1,
      CMD_LOAD_REG  = 2'd2,
      CMD_NONE      = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      SIZE_NONE = 2'd0,
      SIZE_BYTE = 2'd1,
      SIZE_HALF = 2'd2,
      SIZE_WORD = 2'd3
   } size_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] instruction;
      logic [9:0]  preload_index;
      logic [31:0] preload_value;
   } req_word_type;

   // everything the execute stage hands on to the later stages
   typedef struct packed {
      logic [31:0]      pc_next;
      logic             stop_next;
      logic             rf_we;
      logic [REG_W-1:0] rf_waddr;
      logic [31:0]      rf_wdata;
      logic             dest_written;
      logic             is_load;
      size_type         size;
      logic             load_signed;
      logic [1:0]       offset;
      logic             mem_we;
      logic [ROW_W-1:0] mem_row;
      logic [3:0]       mem_be;
      logic [31:0]      mem_wdata;
      logic             mem_written;
      logic             write_zero_error;
      logic             number_overflow;
      logic             address_overflow;
      logic             misaligned;
   } exec_res_type;

   // big-endian byte and halfword extraction from a memory row
   function automatic logic [31:0] load_format(logic [31:0] word, size_type size,
                                               logic sign_ext, logic [1:0] off);
      logic [31:0] shifted;
      logic [7:0]  byte_v;
      logic [15:0] half_v;
      logic [31:0] res;
      shifted = word >> {~off, 3'b000};
      byte_v  = shifted[7:0];
      half_v  = off[1] ? word[15:0] : word[31:16];
      unique case (size)
         SIZE_WORD: res = word;
         SIZE_HALF: res = sign_ext ? {{16{half_v[15]}}, half_v} : {16'h0000, half_v};
         SIZE_BYTE: res = sign_ext ? {{24{byte_v[7]}}, byte_v} : {24'h000000, byte_v};
         SIZE_NONE: res = '0;
      endcase
      return res;
   endfunction

endpackage

/* src/mss_if.sv */
`timescale 1ns / 1ps
interface mss_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] instruction;
   logic [9:0]  preload_index;
   logic [31:0] preload_value;
   modport source (output valid, command, instruction, preload_index, preload_value,
                   input ready);
   modport sink (input valid, command, instruction, preload_index, preload_value,
                 output ready);
endinterface

interface mss_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pc;
   logic        dest_written;
   logic [4:0]  dest_reg;
   logic [31:0] dest_value;
   logic        mem_written;
   logic        write_zero_error;
   logic        number_overflow;
   logic        address_overflow;
   logic        misaligned;
   logic        halted;
   modport source (output valid, pc, dest_written, dest_reg, dest_value, mem_written,
                   write_zero_error, number_overflow, address_overflow, misaligned,
                   halted, input ready);
   modport sink (input valid, pc, dest_written, dest_reg, dest_value, mem_written,
                 write_zero_error, number_overflow, address_overflow, misaligned,
                 halted, output ready);
endinterface

/* src/mss_regfile.sv */
`timescale 1ns / 1ps
module mss_regfile import mss_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [REG_W-1:0] raddr_a,
   input  logic [REG_W-1:0] raddr_b,
   output logic [31:0]      rdata_a,
   output logic [31:0]      rdata_b,
   input  logic             we,
   input  logic [REG_W-1:0] waddr,
   input  logic [31:0]      wdata
);

   logic [31:0]          rf_ff [REG_COUNT];
   logic [REG_COUNT-1:0] vld_ff;
   logic [31:0]          rdata_a_ff;
   logic [31:0]          rdata_b_ff;

   // an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (we) begin
         vld_ff[waddr] <= 1'b1;
      end
   end

   // write-first: a read of the entry being written sees the new word
   always_ff @(posedge clock) begin
      if (we) begin
         rf_ff[waddr] <= wdata;
      end
      if (rd_en) begin
         rdata_a_ff <= (we && waddr == raddr_a) ? wdata :
                       (vld_ff[raddr_a] ? rf_ff[raddr_a] : '0);
         rdata_b_ff <= (we && waddr == raddr_b) ? wdata :
                       (vld_ff[raddr_b] ? rf_ff[raddr_b] : '0);
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

/* src/mss_dmem.sv */
`timescale 1ns / 1ps
module mss_dmem import mss_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [ROW_W-1:0] rd_row,
   output logic [31:0]      rd_data,
   input  logic             we,
   input  logic [ROW_W-1:0] wr_row,
   input  logic [3:0]       be,
   input  logic [31:0]      wdata
);

   logic [31:0]         dmem_ff [MEM_ROWS];
   logic [MEM_ROWS-1:0] vld_ff;
   logic [31:0]         rd_data_ff;
   logic                rd_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (we) begin
            vld_ff[wr_row] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_row];
         end
      end
   end

   // first write to a row zero-fills the bytes not enabled
   always_ff @(posedge clock) begin
      if (we) begin
         for (int i = 0; i < 4; i++) begin
            if (be[i] || !vld_ff[wr_row]) begin
               dmem_ff[wr_row][8*i +: 8] <= be[i] ? wdata[8*i +: 8] : 8'h00;
            end
         end
      end
      if (rd_en) begin
         rd_data_ff <= dmem_ff[rd_row];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

/* src/mss_exec.sv */
`timescale 1ns / 1ps
module mss_exec import mss_pkg::*; (
   input  req_word_type item,
   input  logic [31:0]  a_val,
   input  logic [31:0]  b_val,
   input  logic [31:0]  pc,
   input  logic         stopped,
   output exec_res_type res
);

   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_SLTI    = 6'h0A;
   localparam logic [5:0] OP_ANDI    = 6'h0C;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_NORI    = 6'h0E;
   localparam logic [5:0] OP_LUI     = 6'h0F;
   localparam logic [5:0] OP_LB      = 6'h20;
   localparam logic [5:0] OP_LH      = 6'h21;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_LBU     = 6'h24;
   localparam logic [5:0] OP_LHU     = 6'h25;
   localparam logic [5:0] OP_SB      = 6'h28;
   localparam logic [5:0] OP_SH      = 6'h29;
   localparam logic [5:0] OP_SW      = 6'h2B;
   localparam logic [5:0] OP_HALT    = 6'h3F;
   localparam logic [5:0] FN_SLL     = 6'h00;
   localparam logic [5:0] FN_SRL     = 6'h02;
   localparam logic [5:0] FN_SRA     = 6'h03;
   localparam logic [5:0] FN_JR      = 6'h08;
   localparam logic [5:0] FN_ADD     = 6'h20;
   localparam logic [5:0] FN_SUB     = 6'h22;
   localparam logic [5:0] FN_AND     = 6'h24;
   localparam logic [5:0] FN_OR      = 6'h25;
   localparam logic [5:0] FN_XOR     = 6'h26;
   localparam logic [5:0] FN_NOR     = 6'h27;
   localparam logic [5:0] FN_NAND    = 6'h28;
   localparam logic [5:0] FN_SLT     = 6'h2A;

   typedef enum logic [4:0] {
      K_NONE, K_ADD, K_SUB, K_AND, K_OR, K_XOR, K_NOR, K_NAND, K_SLT, K_SLL,
      K_SRL, K_SRA, K_JR, K_J, K_JAL, K_ADDI, K_ANDI, K_ORI, K_NORI, K_LUI,
      K_SLTI, K_BEQ, K_BNE, K_LW, K_LH, K_LHU, K_LB, K_LBU, K_SW, K_SH, K_SB,
      K_HALT
   } kind_type;

   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd, sh;
   logic [31:0] imm, simm, pc4, addr, btarget, sum_ab, diff_ab, next_pc, value;
   logic [32:0] addr_end;
   logic [31:0] pre_addr;
   kind_type    kind;
   size_type    size;
   logic        wz, nov, aov, mis, wr, store;
   logic [4:0]  dest;
   logic [31:0] st_data;
   logic [3:0]  st_be;

   assign op       = item.instruction[31:26];
   assign fn       = item.instruction[5:0];
   assign rs       = item.instruction[25:21];
   assign rt       = item.instruction[20:16];
   assign rd       = item.instruction[15:11];
   assign sh       = item.instruction[10:6];
   assign imm      = {16'h0000, item.instruction[15:0]};
   assign simm     = {{16{item.instruction[15]}}, item.instruction[15:0]};
   assign pc4      = pc + 32'd4;
   assign addr     = a_val + simm;
   assign btarget  = pc4 + {simm[29:0], 2'b00};
   assign sum_ab   = a_val + b_val;
   assign diff_ab  = a_val - b_val;
   assign pre_addr = {22'h000000, item.preload_index[9:2], 2'b00};

   always_comb begin
      kind = K_NONE;
      if (op == OP_SPECIAL) begin
         unique case (fn)
            FN_ADD:  kind = K_ADD;
            FN_SUB:  kind = K_SUB;
            FN_AND:  kind = K_AND;
            FN_OR:   kind = K_OR;
            FN_XOR:  kind = K_XOR;
            FN_NOR:  kind = K_NOR;
            FN_NAND: kind = K_NAND;
            FN_SLT:  kind = K_SLT;
            FN_SLL:  kind = K_SLL;
            FN_SRL:  kind = K_SRL;
            FN_SRA:  kind = K_SRA;
            FN_JR:   kind = K_JR;
            default: kind = K_NONE;
         endcase
      end else begin
         unique case (op)
            OP_J:    kind = K_J;
            OP_JAL:  kind = K_JAL;
            OP_HALT: kind = K_HALT;
            OP_ADDI: kind = K_ADDI;
            OP_ANDI: kind = K_ANDI;
            OP_ORI:  kind = K_ORI;
            OP_NORI: kind = K_NORI;
            OP_LUI:  kind = K_LUI;
            OP_SLTI: kind = K_SLTI;
            OP_BEQ:  kind = K_BEQ;
            OP_BNE:  kind = K_BNE;
            OP_LW:   kind = K_LW;
            OP_LH:   kind = K_LH;
            OP_LHU:  kind = K_LHU;
            OP_LB:   kind = K_LB;
            OP_LBU:  kind = K_LBU;
            OP_SW:   kind = K_SW;
            OP_SH:   kind = K_SH;
            OP_SB:   kind = K_SB;
            default: kind = K_NONE;
         endcase
      end
   end

   // access size, error detection and the operation itself
   always_comb begin
      size     = SIZE_NONE;
      wz       = 1'b0;
      nov      = 1'b0;
      next_pc  = pc4;
      dest     = '0;
      value    = '0;
      wr       = 1'b0;
      store    = 1'b0;
      st_data  = b_val;
      st_be    = 4'hF;
      unique case (kind)
         K_LW, K_SW:        size = SIZE_WORD;
         K_LH, K_LHU, K_SH: size = SIZE_HALF;
         K_LB, K_LBU, K_SB: size = SIZE_BYTE;
         default:           size = SIZE_NONE;
      endcase
      if (kind >= K_ADD && kind <= K_SRA) begin
         wz = (rd == 5'd0) && !(kind == K_SLL && rs == 5'd0 && rt == 5'd0);
      end else if ((kind >= K_ADDI && kind <= K_SLTI) || (kind >= K_LW && kind <= K_LBU)) begin
         wz = (rt == 5'd0);
      end
      if (kind == K_ADD) begin
         nov = (a_val[31] ^ sum_ab[31]) & (b_val[31] ^ sum_ab[31]);
      end else if (kind == K_SUB) begin
         nov = (a_val[31] ^ b_val[31]) & (a_val[31] ^ diff_ab[31]);
      end else if (kind == K_ADDI || size != SIZE_NONE) begin
         nov = (a_val[31] ^ addr[31]) & (simm[31] ^ addr[31]);
      end else if (kind == K_BEQ || kind == K_BNE) begin
         nov = (pc4[31] ^ btarget[31]) & (simm[29] ^ btarget[31]);
      end
      unique case (kind)
         K_ADD:  begin dest = rd; value = sum_ab; wr = 1'b1; end
         K_SUB:  begin dest = rd; value = diff_ab; wr = 1'b1; end
         K_AND:  begin dest = rd; value = a_val & b_val; wr = 1'b1; end
         K_OR:   begin dest = rd; value = a_val | b_val; wr = 1'b1; end
         K_XOR:  begin dest = rd; value = a_val ^ b_val; wr = 1'b1; end
         K_NOR:  begin dest = rd; value = ~(a_val | b_val); wr = 1'b1; end
         K_NAND: begin dest = rd; value = ~(a_val & b_val); wr = 1'b1; end
         K_SLT:  begin
            dest = rd; value = {31'd0, $signed(a_val) < $signed(b_val)}; wr = 1'b1;
         end
         K_SLL:  begin dest = rd; value = b_val << sh; wr = 1'b1; end
         K_SRL:  begin dest = rd; value = b_val >> sh; wr = 1'b1; end
         K_SRA:  begin dest = rd; value = $unsigned($signed(b_val) >>> sh); wr = 1'b1; end
         K_JR:   next_pc = a_val;
         K_J:    next_pc = {pc4[31:28], item.instruction[25:0], 2'b00};
         K_JAL:  begin
            next_pc = {pc4[31:28], item.instruction[25:0], 2'b00};
            dest = 5'd31; value = pc4; wr = 1'b1;
         end
         K_ADDI: begin dest = rt; value = addr; wr = 1'b1; end
         K_ANDI: begin dest = rt; value = a_val & imm; wr = 1'b1; end
         K_ORI:  begin dest = rt; value = a_val | imm; wr = 1'b1; end
         K_NORI: begin dest = rt; value = ~(a_val | imm); wr = 1'b1; end
         K_LUI:  begin dest = rt; value = {imm[15:0], 16'h0000}; wr = 1'b1; end
         K_SLTI: begin
            dest = rt; value = {31'd0, $signed(a_val) < $signed(simm)}; wr = 1'b1;
         end
         K_BEQ:  if (a_val == b_val) next_pc = btarget;
         K_BNE:  if (a_val != b_val) next_pc = btarget;
         K_LW, K_LH, K_LHU, K_LB, K_LBU: begin dest = rt; wr = 1'b1; end
         K_SW:   store = 1'b1;
         K_SH:   begin
            store = 1'b1; st_data = {2{b_val[15:0]}};
            st_be = addr[1] ? 4'b0011 : 4'b1100;
         end
         K_SB:   begin
            store = 1'b1; st_data = {4{b_val[7:0]}};
            st_be = 4'b0001 << ~addr[1:0];
         end
         default: ;
      endcase
   end

   always_comb begin
      unique case (size)
         SIZE_WORD: addr_end = {1'b0, addr} + 33'd4;
         SIZE_HALF: addr_end = {1'b0, addr} + 33'd2;
         SIZE_BYTE: addr_end = {1'b0, addr} + 33'd1;
         SIZE_NONE: addr_end = {1'b0, addr};
      endcase
      aov = (size != SIZE_NONE) && (addr[31] || addr_end > 33'(DATA_BYTES));
      mis = (size == SIZE_WORD && addr[1:0] != 2'b00) || (size == SIZE_HALF && addr[0]);
   end

   always_comb begin
      res             = '0;
      res.pc_next     = pc;
      res.stop_next   = stopped;
      res.size        = size;
      res.load_signed = (kind == K_LH || kind == K_LB);
      res.offset      = addr[1:0];
      res.mem_row     = addr[ROW_W+1:2];
      res.mem_be      = st_be;
      res.mem_wdata   = st_data;
      unique case (command_type'(item.command))
         CMD_LOAD_WORD: begin
            res.mem_row = pre_addr[ROW_W+1:2];
            if ({1'b0, pre_addr} + 33'd4 <= 33'(DATA_BYTES)) begin
               res.mem_we    = 1'b1;
               res.mem_be    = 4'hF;
               res.mem_wdata = item.preload_value;
            end
         end
         CMD_LOAD_REG: begin
            if (item.preload_index != '0 && 32'(item.preload_index) < REG_COUNT) begin
               res.rf_we    = 1'b1;
               res.rf_waddr = item.preload_index[REG_W-1:0];
               res.rf_wdata = item.preload_value;
            end
         end
         CMD_EXEC: begin
            if (!stopped) begin
               if (kind == K_HALT) begin
                  res.stop_next = 1'b1;
               end else begin
                  res.write_zero_error = wz;
                  res.number_overflow  = nov;
                  res.address_overflow = aov;
                  res.misaligned       = mis;
                  if (aov || mis) begin
                     res.stop_next = 1'b1;
                  end else if (wz) begin
                     res.pc_next = pc4;
                  end else begin
                     res.pc_next      = next_pc;
                     res.rf_we        = wr && dest != 5'd0;
                     res.dest_written = wr && dest != 5'd0;
                     res.rf_waddr     = dest[REG_W-1:0];
                     res.rf_wdata     = value;
                     res.is_load      = wr && dest != 5'd0 && size != SIZE_NONE;
                     res.mem_we       = store;
                     res.mem_written  = store;
                  end
               end
            end
         end
         CMD_NONE: ;
      endcase
   end

endmodule

/* src/mips_subset_cpu_step.sv */
// path: execute, write-back and result registers lie between request and rsp_ch
// throughput: one word per cycle unless rsp_ch stalls; loads forward to the next word
// pipeline: execute stage, write-back stage (data memory read), result register
// reset: synchronous, clears pipeline valids, pc to zero, start_pc to zero, halt flag;
// register file and data memory read as zero via per-entry valid bits, no clearing pass
`timescale 1ns / 1ps
`include "mips_subset_cpu_step_macros.svh"
module mips_subset_cpu_step import mss_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [31:0]   csr_wdata,
   mss_req_if.sink       req_ch,
   mss_rsp_if.source     rsp_ch
);

   // architectural state
   logic [31:0]  start_pc_ff, pc_ff;
   logic         stopped_ff;

   // pipeline registers
   logic         ex_valid_ff, wb_valid_ff, out_valid_ff;
   req_word_type ex_item_ff;
   exec_res_type wb_ff;
   exec_res_type exec_res;

   // result register
   logic [31:0]  out_pc_ff, out_dest_value_ff;
   logic         out_dest_written_ff, out_mem_written_ff, out_wz_ff, out_nov_ff;
   logic         out_aov_ff, out_mis_ff, out_halted_ff;
   logic [4:0]   out_dest_reg_ff;
   logic         wb_halted_ff;

   logic         advance;
   req_word_type req_word;
   logic [31:0]  rf_a, rf_b, a_fwd, b_fwd;
   logic [31:0]  mem_rdata, wb_value;
   logic         rf_we;
   logic [REG_W-1:0] rf_waddr;
   logic         dmem_we;

   // whole pipe moves together unless the result register is held
   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   assign req_word.command       = req_ch.command;
   assign req_word.instruction   = req_ch.instruction;
   assign req_word.preload_index = req_ch.preload_index;
   assign req_word.preload_value = req_ch.preload_value;

   // register file: read ports addressed from the incoming word
   mss_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (advance),
      .raddr_a (req_ch.instruction[21 +: REG_W]),
      .raddr_b (req_ch.instruction[16 +: REG_W]),
      .rdata_a (rf_a),
      .rdata_b (rf_b),
      .we      (rf_we),
      .waddr   (rf_waddr),
      .wdata   (wb_value)
   );

   // load result in write-back, also the forward source for the execute stage
   assign wb_value = wb_ff.is_load ?
                     load_format(mem_rdata, wb_ff.size, wb_ff.load_signed, wb_ff.offset) :
                     wb_ff.rf_wdata;
   assign rf_we    = advance && wb_valid_ff && wb_ff.rf_we;
   assign rf_waddr = wb_ff.rf_waddr;

   // forward from write-back; older writes are caught by the write-first read
   assign a_fwd = (wb_valid_ff && wb_ff.rf_we &&
                   wb_ff.rf_waddr == ex_item_ff.instruction[21 +: REG_W]) ? wb_value : rf_a;
   assign b_fwd = (wb_valid_ff && wb_ff.rf_we &&
                   wb_ff.rf_waddr == ex_item_ff.instruction[16 +: REG_W]) ? wb_value : rf_b;

   mss_exec u_exec (
      .item    (ex_item_ff),
      .a_val   (a_fwd),
      .b_val   (b_fwd),
      .pc      (pc_ff),
      .stopped (stopped_ff),
      .res     (exec_res)
   );

   // stores and preload words land at the end of execute, loads read there too
   assign dmem_we = advance && ex_valid_ff && exec_res.mem_we;

   mss_dmem u_dmem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (advance),
      .rd_row  (exec_res.mem_row),
      .rd_data (mem_rdata),
      .we      (dmem_we),
      .wr_row  (exec_res.mem_row),
      .be      (exec_res.mem_be),
      .wdata   (exec_res.mem_wdata)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         start_pc_ff  <= '0;
         pc_ff        <= '0;
         stopped_ff   <= 1'b0;
         ex_valid_ff  <= 1'b0;
         wb_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            start_pc_ff <= csr_wdata;
            pc_ff       <= csr_wdata;
         end else if (advance && ex_valid_ff) begin
            pc_ff <= exec_res.pc_next;
         end
         if (advance && ex_valid_ff) begin
            stopped_ff <= exec_res.stop_next;
         end
         if (advance) begin
            ex_valid_ff  <= req_ch.valid;
            wb_valid_ff  <= ex_valid_ff;
            out_valid_ff <= wb_valid_ff;
         end
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (advance) begin
         ex_item_ff          <= req_word;
         wb_ff               <= exec_res;
         wb_halted_ff        <= exec_res.stop_next;
         out_pc_ff           <= wb_ff.pc_next;
         out_dest_written_ff <= wb_ff.dest_written;
         out_dest_reg_ff     <= wb_ff.dest_written ? 5'(wb_ff.rf_waddr) : 5'd0;
         out_dest_value_ff   <= wb_ff.dest_written ? wb_value : 32'd0;
         out_mem_written_ff  <= wb_ff.mem_written;
         out_wz_ff           <= wb_ff.write_zero_error;
         out_nov_ff          <= wb_ff.number_overflow;
         out_aov_ff          <= wb_ff.address_overflow;
         out_mis_ff          <= wb_ff.misaligned;
         out_halted_ff       <= wb_halted_ff;
      end
   end

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.pc               = out_pc_ff;
   assign rsp_ch.dest_written     = out_dest_written_ff;
   assign rsp_ch.dest_reg         = out_dest_reg_ff;
   assign rsp_ch.dest_value       = out_dest_value_ff;
   assign rsp_ch.mem_written      = out_mem_written_ff;
   assign rsp_ch.write_zero_error = out_wz_ff;
   assign rsp_ch.number_overflow  = out_nov_ff;
   assign rsp_ch.address_overflow = out_aov_ff;
   assign rsp_ch.misaligned       = out_mis_ff;
   assign rsp_ch.halted           = out_halted_ff;

   // $0 is never written
   `MSS_ASSERT_SAME(a_rf_no_zero, clock, reset, rf_we, rf_waddr != '0, "write to register zero")
   // data memory changes only as an execute word moves on
   `MSS_ASSERT_SAME(a_dmem_we_ex, clock, reset, dmem_we, ex_valid_ff && advance, "memory write outside execute")
   // only reset clears the halt
   `MSS_ASSERT_NEXT(a_stop_holds, clock, reset, stopped_ff, stopped_ff, "halt flag dropped")
   // an address or alignment error halts the machine
   `MSS_ASSERT_NEXT(a_err_halts, clock, reset, advance && ex_valid_ff && (exec_res.address_overflow || exec_res.misaligned), stopped_ff, "access error without halt")

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// mips subset processor step: every request word is run through a local model of the
// processor (register file, pc, byte memory, stop flag) and each response word is checked
// against the oldest predicted response
module tb;
   import mss_pkg::*;

   // opcodes
   localparam logic [5:0] OP_RTYPE = 6'h00, OP_J    = 6'h02, OP_JAL  = 6'h03, OP_BEQ  = 6'h04;
   localparam logic [5:0] OP_BNE   = 6'h05, OP_ADDI = 6'h08, OP_SLTI = 6'h0A, OP_ANDI = 6'h0C;
   localparam logic [5:0] OP_ORI   = 6'h0D, OP_NORI = 6'h0E, OP_LUI  = 6'h0F, OP_LB   = 6'h20;
   localparam logic [5:0] OP_LH    = 6'h21, OP_LW   = 6'h23, OP_LBU  = 6'h24, OP_LHU  = 6'h25;
   localparam logic [5:0] OP_SB    = 6'h28, OP_SH   = 6'h29, OP_SW   = 6'h2B, OP_HALT = 6'h3F;
   localparam logic [5:0] OP_UNUSED = 6'h01;
   // r-type function codes
   localparam logic [5:0] FN_SLL = 6'h00, FN_SRL = 6'h02, FN_SRA = 6'h03, FN_JR  = 6'h08;
   localparam logic [5:0] FN_ADD = 6'h20, FN_SUB = 6'h22, FN_AND = 6'h24, FN_OR  = 6'h25;
   localparam logic [5:0] FN_XOR = 6'h26, FN_NOR = 6'h27, FN_NAND = 6'h28, FN_SLT = 6'h2A;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [31:0] pc;
      logic        dest_written;
      logic [4:0]  dest_reg;
      logic [31:0] dest_value;
      logic        mem_written;
      logic        write_zero_error;
      logic        number_overflow;
      logic        address_overflow;
      logic        misaligned;
      logic        halted;
   } outcome_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;

   mss_req_if req_ch ();
   mss_rsp_if rsp_ch ();

   mips_subset_cpu_step i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   always #5 clock = ~clock;

   // local copy of the processor state
   logic [31:0] gpr [32];
   logic [7:0]  dmem [DATA_BYTES];
   logic [31:0] prog_ctr;
   logic        machine_stopped;

   outcome_t pending_results [$];
   int       errors = 0;
   int       cycles = 0;
   int       send_idle_pct = 0;
   int       recv_idle_pct = 0;

   function automatic logic add_ovf(logic [31:0] a, logic [31:0] b, logic [31:0] r);
      return (a[31] ^ r[31]) & (b[31] ^ r[31]);
   endfunction

   // one request word applied to the local state, returning the response it should give
   function automatic outcome_t cpu_step(command_type cmd, logic [31:0] ins,
                                         logic [9:0] idx, logic [31:0] val);
      outcome_t    o;
      logic [5:0]  op, fn;
      logic [4:0]  rs, rt, rd, sh, d;
      logic [15:0] imm;
      logic [31:0] simm, a, b, pc4, addr, bt, nxt, v;
      logic [32:0] span;
      logic [9:0]  ma;
      int          size;
      logic        r_alu, i_alu, ld, wr;
      o = '0;
      case (cmd)
         CMD_LOAD_WORD: begin
            ma = {idx[9:2], 2'b00};
            {dmem[ma], dmem[ma + 1], dmem[ma + 2], dmem[ma + 3]} = val;
         end
         CMD_LOAD_REG: if (idx != 0 && idx < 32) gpr[idx[4:0]] = val;
         CMD_EXEC: if (!machine_stopped) begin
            op = ins[31:26]; fn = ins[5:0];
            rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11]; sh = ins[10:6];
            imm = ins[15:0]; simm = {{16{imm[15]}}, imm};
            a = gpr[rs]; b = gpr[rt];
            pc4 = prog_ctr + 32'd4; addr = a + simm; bt = pc4 + (simm << 2);
            r_alu = op == OP_RTYPE && fn inside {FN_ADD, FN_SUB, FN_AND, FN_OR, FN_XOR,
                    FN_NOR, FN_NAND, FN_SLT, FN_SLL, FN_SRL, FN_SRA};
            i_alu = op inside {OP_ADDI, OP_ANDI, OP_ORI, OP_NORI, OP_LUI, OP_SLTI};
            ld = op inside {OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU};
            size = op inside {OP_LW, OP_SW} ? 4 : op inside {OP_LH, OP_LHU, OP_SH} ? 2 :
                   op inside {OP_LB, OP_LBU, OP_SB} ? 1 : 0;
            if (op == OP_HALT) begin
               machine_stopped = 1'b1;
            end else begin
               if (r_alu) o.write_zero_error = rd == 0 && !(fn == FN_SLL && rs == 0 && rt == 0);
               else if (i_alu || ld) o.write_zero_error = rt == 0;
               if (op == OP_RTYPE && fn == FN_ADD) o.number_overflow = add_ovf(a, b, a + b);
               else if (op == OP_RTYPE && fn == FN_SUB) begin
                  v = a - b;
                  o.number_overflow = (a[31] ^ b[31]) & (a[31] ^ v[31]);
               end
               else if (op == OP_ADDI || size != 0) o.number_overflow = add_ovf(a, simm, addr);
               else if (op inside {OP_BEQ, OP_BNE})
                  o.number_overflow = add_ovf(pc4, simm << 2, bt);
               if (size != 0) begin
                  span = {1'b0, addr} + 33'(size);
                  o.address_overflow = addr[31] || span > DATA_BYTES;
                  o.misaligned = (addr & 32'(size - 1)) != 0;
               end
               ma = addr[9:0];
               if (o.address_overflow || o.misaligned) begin
                  machine_stopped = 1'b1;
               end else if (o.write_zero_error) begin
                  prog_ctr = pc4;
               end else begin
                  nxt = pc4; d = rt; v = '0; wr = i_alu || ld;
                  if (op == OP_RTYPE) begin
                     d = rd; wr = r_alu;
                     case (fn)
                        FN_ADD:  v = a + b;
                        FN_SUB:  v = a - b;
                        FN_AND:  v = a & b;
                        FN_OR:   v = a | b;
                        FN_XOR:  v = a ^ b;
                        FN_NOR:  v = ~(a | b);
                        FN_NAND: v = ~(a & b);
                        FN_SLT:  v = {31'd0, $signed(a) < $signed(b)};
                        FN_SLL:  v = b << sh;
                        FN_SRL:  v = b >> sh;
                        FN_SRA:  v = $signed(b) >>> sh;
                        FN_JR:   nxt = a;
                        default: ;
                     endcase
                  end else begin
                     case (op)
                        OP_J:    nxt = {pc4[31:28], ins[25:0], 2'b00};
                        OP_JAL: begin
                           nxt = {pc4[31:28], ins[25:0], 2'b00};
                           d = 5'd31; v = pc4; wr = 1'b1;
                        end
                        OP_ADDI: v = addr;
                        OP_ANDI: v = a & {16'h0, imm};
                        OP_ORI:  v = a | {16'h0, imm};
                        OP_NORI: v = ~(a | {16'h0, imm});
                        OP_LUI:  v = {imm, 16'h0};
                        OP_SLTI: v = {31'd0, $signed(a) < $signed(simm)};
                        OP_BEQ:  if (a == b) nxt = bt;
                        OP_BNE:  if (a != b) nxt = bt;
                        OP_LW:   v = {dmem[ma], dmem[ma + 1], dmem[ma + 2], dmem[ma + 3]};
                        OP_LH:   v = {{16{dmem[ma][7]}}, dmem[ma], dmem[ma + 1]};
                        OP_LHU:  v = {16'h0, dmem[ma], dmem[ma + 1]};
                        OP_LB:   v = {{24{dmem[ma][7]}}, dmem[ma]};
                        OP_LBU:  v = {24'h0, dmem[ma]};
                        OP_SW: begin
                           {dmem[ma], dmem[ma + 1], dmem[ma + 2], dmem[ma + 3]} = b;
                           o.mem_written = 1'b1;
                        end
                        OP_SH: begin
                           {dmem[ma], dmem[ma + 1]} = b[15:0];
                           o.mem_written = 1'b1;
                        end
                        OP_SB: begin
                           dmem[ma] = b[7:0];
                           o.mem_written = 1'b1;
                        end
                        default: ;
                     endcase
                  end
                  if (wr && d != 0) begin
                     gpr[d] = v;
                     o.dest_written = 1'b1; o.dest_reg = d; o.dest_value = v;
                  end
                  prog_ctr = nxt;
               end
            end
         end
         default: ;
      endcase
      o.pc = prog_ctr;
      o.halted = machine_stopped;
      return o;
   endfunction

   function automatic logic [31:0] r_word(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [4:0] sh);
      return {OP_RTYPE, rs, rt, rd, sh, fn};
   endfunction

   function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   // random instruction that never halts the machine: memory accesses stay in range
   function automatic logic [31:0] random_instr();
      logic [5:0]  fns [11] = '{FN_ADD, FN_SUB, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_NAND,
                                FN_SLT, FN_SLL, FN_SRL, FN_JR};
      logic [5:0]  iops [10] = '{OP_ADDI, OP_ANDI, OP_ORI, OP_NORI, OP_LUI, OP_SLTI,
                                 OP_BEQ, OP_BNE, OP_J, OP_JAL};
      logic [5:0]  mops [8] = '{OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU, OP_SW, OP_SH, OP_SB};
      logic [31:0] ins, target, diff;
      logic [5:0]  op;
      logic [4:0]  rs;
      int          pick, size;
      ins = $urandom;
      pick = $urandom_range(99);
      if (pick < 10) begin
         // raw word, opcode kept off halt and memory
         if (ins[31:26] == OP_HALT || ins[31:26] inside {mops}) ins[31:26] = OP_UNUSED;
      end else if (pick < 50) begin
         ins = r_word(pick < 46 ? fns[$urandom_range(10)] : FN_SRA,
                      5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom));
      end else if (pick < 70) begin
         ins[31:26] = iops[$urandom_range(9)];
      end else begin
         op = mops[$urandom_range(7)];
         size = op inside {OP_LW, OP_SW} ? 4 : op inside {OP_LH, OP_LHU, OP_SH} ? 2 : 1;
         target = $urandom_range(DATA_BYTES - size) & ~32'(size - 1);
         rs = 5'($urandom);
         diff = target - gpr[rs];
         if ($signed(diff) > 32767 || $signed(diff) < -32768) begin
            rs = 5'd0; diff = target;
         end
         ins = i_word(op, rs, 5'($urandom), diff[15:0]);
      end
      return ins;
   endfunction

   // response side: random back-pressure and checking
   always @(negedge clock) rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

   function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      outcome_t want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual pc %h", $time, rsp_ch.pc);
            errors++;
         end else begin
            want = pending_results.pop_front();
            check_field("pc", want.pc, rsp_ch.pc);
            check_field("dest_written", want.dest_written, rsp_ch.dest_written);
            check_field("dest_reg", want.dest_reg, rsp_ch.dest_reg);
            check_field("dest_value", want.dest_value, rsp_ch.dest_value);
            check_field("mem_written", want.mem_written, rsp_ch.mem_written);
            check_field("write_zero_error", want.write_zero_error, rsp_ch.write_zero_error);
            check_field("number_overflow", want.number_overflow, rsp_ch.number_overflow);
            check_field("address_overflow", want.address_overflow, rsp_ch.address_overflow);
            check_field("misaligned", want.misaligned, rsp_ch.misaligned);
            check_field("halted", want.halted, rsp_ch.halted);
         end
      end
   end

   // request side: one word, with random idle cycles ahead of it
   task automatic send_word(command_type cmd, logic [31:0] ins = '0, logic [9:0] idx = '0,
                            logic [31:0] val = '0);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.command = cmd;
      req_ch.instruction = ins;
      req_ch.preload_index = idx;
      req_ch.preload_value = val;
      do @(posedge clock); while (!req_ch.ready);
      pending_results.push_back(cpu_step(cmd, ins, idx, val));
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task automatic exec(logic [31:0] ins);
      send_word(CMD_EXEC, ins);
   endtask

   // hold off until every predicted word has come back, then let the pipe settle
   task automatic drain();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (6) @(negedge clock);
   endtask

   // start_pc write: the pc takes the new value at once
   task automatic write_start_pc(logic [31:0] value);
      drain();
      csr_we = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      prog_ctr = value;
   endtask

   task automatic test_directed();
      send_word(CMD_LOAD_REG, '0, 10'd1, 32'h7FFF_FFFF);
      send_word(CMD_LOAD_REG, '0, 10'd2, 32'h8000_0000);
      send_word(CMD_LOAD_REG, '0, 10'd3, 32'hFFFF_FFFF);
      send_word(CMD_LOAD_REG, '0, 10'd0, 32'h1234_5678);     // $0 stays zero
      send_word(CMD_LOAD_REG, '0, 10'h3FF, 32'hDEAD_BEEF);   // out of register range
      send_word(CMD_LOAD_WORD, '0, 10'h3FF, 32'h80FF_7F01);  // lands at the top word
      send_word(CMD_NONE, 32'hFFFF_FFFF, 10'h3FF, 32'hFFFF_FFFF);
      exec(r_word(FN_ADD, 5'd1, 5'd1, 5'd4, 5'd0));           // positive overflow
      exec(r_word(FN_SUB, 5'd2, 5'd1, 5'd5, 5'd0));           // negative overflow
      exec(r_word(FN_NAND, 5'd3, 5'd1, 5'd6, 5'd0));
      exec(r_word(FN_SLL, 5'd0, 5'd0, 5'd0, 5'd0));           // plain nop
      exec(r_word(FN_SLL, 5'd0, 5'd3, 5'd0, 5'd4));           // write to $0
      exec(r_word(FN_SRL, 5'd0, 5'd2, 5'd7, 5'd31));          // logical
      exec(r_word(FN_SRA, 5'd0, 5'd2, 5'd8, 5'd31));
      exec(i_word(OP_NORI, 5'd0, 5'd9, 16'hFFFF));
      exec(i_word(OP_ANDI, 5'd3, 5'd10, 16'h8001));
      exec(i_word(OP_LUI, 5'd0, 5'd11, 16'hFFFF));
      exec(i_word(OP_SLTI, 5'd2, 5'd12, 16'h7FFF));
      exec(i_word(OP_LH, 5'd0, 5'd13, 16'd1020));             // sign-extended half
      exec(i_word(OP_LB, 5'd0, 5'd14, 16'd1023));
      exec(i_word(OP_SW, 5'd0, 5'd3, 16'd1020));
      exec(i_word(OP_BEQ, 5'd0, 5'd0, 16'h8000));             // taken, backwards
      exec({OP_JAL, 26'h3FF_FFFF});
      exec(r_word(FN_JR, 5'd3, 5'd0, 5'd0, 5'd0));            // jump to rs
      exec(i_word(OP_BNE, 5'd0, 5'd0, 16'h7FFF));             // not taken
   endtask

   task automatic test_random(int count, bit pause_midway);
      int pick;
      for (int i = 0; i < count; i++) begin
         if (pause_midway && i == count / 2) drain();
         pick = $urandom_range(99);
         if (pick < 85) exec(random_instr());
         else if (pick < 93) send_word(CMD_LOAD_REG, '0, 10'($urandom), $urandom);
         else if (pick < 98) send_word(CMD_LOAD_WORD, '0, 10'($urandom), $urandom);
         else send_word(CMD_NONE, $urandom, 10'($urandom), $urandom);
      end
   endtask

   // the machine stops for good here, so this runs last
   task automatic test_stop();
      exec(i_word(OP_SW, 5'd0, 5'd1, 16'd1023));              // out of range and misaligned
      exec({OP_HALT, 26'h0});                                  // no effect once stopped
      send_word(CMD_LOAD_REG, '0, 10'd1, 32'h0000_0005);
      send_word(CMD_LOAD_WORD, '0, 10'd4, 32'hA5A5_A5A5);
      exec(r_word(FN_ADD, 5'd1, 5'd1, 5'd2, 5'd0));
      write_start_pc(32'h0000_1000);
      exec(r_word(FN_ADD, 5'd1, 5'd1, 5'd2, 5'd0));
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.command = CMD_EXEC;
      req_ch.instruction = '0;
      req_ch.preload_index = '0;
      req_ch.preload_value = '0;
      rsp_ch.ready = 1'b0;
      foreach (gpr[i]) gpr[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      prog_ctr = '0;
      machine_stopped = 1'b0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // sender idles more lightly than the receiver
      send_idle_pct = 38; recv_idle_pct = 47;
      write_start_pc(32'hFFFF_FFFC);
      test_directed();
      test_random(300, 1'b0);

      // roles swapped, one full drain in the middle
      write_start_pc(32'h0000_0000);
      send_idle_pct = 47; recv_idle_pct = 38;
      test_random(300, 1'b1);

      // back to back
      write_start_pc($urandom);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(300, 1'b0);
      write_start_pc(32'hFFFF_FFFF);
      test_random(20, 1'b0);

      test_stop();
      drain();
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
